// ===== hdl/rcdr_pkg.sv =====
// Package: types and constants for the refcounted cache with deferred retire
package rcdr_pkg;
  localparam int Entries = 16;
  localparam int SlotW = $clog2(Entries);
  localparam int CntW = $clog2(Entries + 1);
  localparam logic [31:0] RefMax = 32'hFFFF_FFFF;
  localparam logic [39:0] FrameMax = 40'hFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    FN_ENSURE = 2'd0, FN_RELEASE = 2'd1, FN_TICK = 2'd2, FN_LOOKUP = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    ST_HIT = 4'd0, ST_SAT_HIT = 4'd1, ST_UPLOADED = 4'd2, ST_UP_FAIL = 4'd3,
    ST_FULL = 4'd4, ST_NOT_FOUND = 4'd5, ST_RELEASED = 4'd6, ST_FREED = 4'd7,
    ST_TICK_DONE = 4'd8, ST_LK_HIT = 4'd9, ST_LK_MISS = 4'd10
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_DISPATCH, S_FREE, S_CANCEL, S_SHIFT, S_STAMP, S_SCAN,
    S_EXAM, S_OUT
  } state_e;

  localparam logic [0:0] RegFrames = 1'd0;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  key_kind;
    logic [63:0] key_hash;
    logic        upload_ok;
    logic [31:0] upload_handle;
    logic [39:0] current_frame;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] handle;
    logic [31:0] ref_count;
    logic        unreferenced;
    logic        retire_cancelled;
    logic        last;
  } out_item_t;
endpackage

// ===== hdl/refcounted_cache_deferred_retire.sv =====
// Top level: refcounted cache with deferred retire, one sequencer over the table
// Ensure/release/lookup: key scan, one entry per cycle, then dispatch.
// Free-slot search and retire-queue search/shift walk the table or queue entry by entry.
// Tick: a stamp pass over the queue, then a scan that examines and removes each expired record.
// in_stall_o is low only when idle; a waiting result holds the next item at dispatch.
// Reset empties the table and queue; frames_in_flight resets to 2.
module refcounted_cache_deferred_retire (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rcdr_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rcdr_pkg::out_item_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [0:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import rcdr_pkg::*;

  logic [7:0] fif_q;
  logic [Entries-1:0] ev_q;
  logic [7:0]  ek_q [Entries];
  logic [63:0] eh_q [Entries];
  logic [31:0] ed_q [Entries];
  logic [31:0] er_q [Entries];
  logic [SlotW-1:0] rs_q [Entries];
  logic [39:0] rd_q [Entries];
  logic [Entries-1:0] rst_q;
  logic [CntW-1:0] rc_q;

  state_e st_q;
  in_item_t it_q;
  out_item_t o_q;
  logic ov_q;
  logic [CntW-1:0] i_q;
  logic [SlotW-1:0] s_q;
  logic hit_q, canc_q, after_q;
  logic [39:0] dl_q;

  wire [SlotW-1:0] ix = i_q[SlotW-1:0];
  wire [SlotW-1:0] sl = rs_q[ix];
  wire [40:0] dsum = {1'b0, in_data_i.current_frame} + {33'd0, fif_q};

  assign pready = 1'b1;
  assign prdata = (paddr == RegFrames) ? {24'd0, fif_q} : 32'd0;
  assign in_stall_o = (st_q != S_IDLE);
  assign out_valid_o = ov_q;
  assign out_data_o = o_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fif_q <= 8'd2;
    end else if (psel && penable && pwrite && paddr == RegFrames) begin
      fif_q <= pwdata[7:0];
    end
  end

  task automatic put(input status_e s, input logic [31:0] h, input logic [31:0] r,
                     input logic u, input logic c, input logic l);
    o_q <= '{status: s, handle: h, ref_count: r, unreferenced: u,
             retire_cancelled: c, last: l};
    ov_q <= 1'b1;
  endtask

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      ov_q <= 1'b0;
      ev_q <= '0;
      rc_q <= '0;
      i_q <= '0;
      hit_q <= 1'b0;
      canc_q <= 1'b0;
      after_q <= 1'b0;
    end else begin
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      unique case (st_q)
        S_IDLE: if (in_valid_i) begin
          it_q <= in_data_i;
          i_q <= '0;
          hit_q <= 1'b0;
          canc_q <= 1'b0;
          dl_q <= dsum[40] ? FrameMax : dsum[39:0];
          st_q <= (func_e'(in_data_i.func) == FN_TICK) ? S_STAMP : S_FIND;
        end
        S_FIND: begin
          if (ev_q[ix] && ek_q[ix] == it_q.key_kind && eh_q[ix] == it_q.key_hash) begin
            hit_q <= 1'b1;
            s_q <= ix;
            st_q <= S_DISPATCH;
          end else if (i_q == CntW'(Entries - 1)) begin
            st_q <= S_DISPATCH;
          end
          i_q <= i_q + 1'b1;
        end
        S_DISPATCH: if (!ov_q) begin
          i_q <= '0;
          st_q <= S_IDLE;
          unique case (func_e'(it_q.func))
            FN_ENSURE:
              if (hit_q) begin
                if (er_q[s_q] == RefMax)
                  put(ST_SAT_HIT, ed_q[s_q], RefMax, 1'b0, 1'b0, 1'b1);
                else if (er_q[s_q] == 32'd0 && !canc_q && !after_q) st_q <= S_CANCEL;
                else begin
                  er_q[s_q] <= er_q[s_q] + 32'd1;
                  put(ST_HIT, ed_q[s_q], er_q[s_q] + 32'd1, 1'b0, canc_q, 1'b1);
                end
              end else if (!it_q.upload_ok) put(ST_UP_FAIL, 32'd0, 32'd0, 1'b0, 1'b0, 1'b1);
              else st_q <= S_FREE;
            FN_RELEASE:
              if (!hit_q) put(ST_NOT_FOUND, 32'd0, 32'd0, 1'b0, 1'b0, 1'b1);
              else begin
                if (er_q[s_q] != 32'd0) begin
                  er_q[s_q] <= er_q[s_q] - 32'd1;
                  if (er_q[s_q] == 32'd1 && rc_q < CntW'(Entries)) begin
                    rs_q[rc_q[SlotW-1:0]] <= s_q;
                    rst_q[rc_q[SlotW-1:0]] <= 1'b0;
                    rd_q[rc_q[SlotW-1:0]] <= '0;
                    rc_q <= rc_q + 1'b1;
                  end
                end
                put(ST_RELEASED, ed_q[s_q], (er_q[s_q] == 32'd0) ? 32'd0 : er_q[s_q] - 32'd1,
                    er_q[s_q] <= 32'd1, 1'b0, 1'b1);
              end
            FN_LOOKUP:
              if (hit_q) put(ST_LK_HIT, ed_q[s_q], er_q[s_q], 1'b0, 1'b0, 1'b1);
              else put(ST_LK_MISS, 32'd0, 32'd0, 1'b0, 1'b0, 1'b1);
            default: put(ST_TICK_DONE, 32'd0, 32'd0, 1'b0, 1'b0, 1'b1);
          endcase
          after_q <= 1'b0;
        end
        S_FREE: begin
          if (!ev_q[ix]) begin
            ev_q[ix] <= 1'b1;
            ek_q[ix] <= it_q.key_kind;
            eh_q[ix] <= it_q.key_hash;
            ed_q[ix] <= it_q.upload_handle;
            er_q[ix] <= 32'd1;
            put(ST_UPLOADED, it_q.upload_handle, 32'd1, 1'b0, 1'b0, 1'b1);
            st_q <= S_IDLE;
          end else if (i_q == CntW'(Entries - 1)) begin
            put(ST_FULL, 32'd0, 32'd0, 1'b0, 1'b0, 1'b1);
            st_q <= S_IDLE;
          end
          i_q <= i_q + 1'b1;
        end
        S_CANCEL: begin
          if (i_q >= rc_q) begin
            after_q <= 1'b1;
            st_q <= S_DISPATCH;
          end else if (rs_q[ix] == s_q) begin
            canc_q <= 1'b1;
            st_q <= S_SHIFT;
          end else i_q <= i_q + 1'b1;
        end
        S_SHIFT: begin
          if (i_q + 1'b1 < rc_q) begin
            rs_q[ix] <= rs_q[SlotW'(ix + 1'b1)];
            rd_q[ix] <= rd_q[SlotW'(ix + 1'b1)];
            rst_q[ix] <= rst_q[SlotW'(ix + 1'b1)];
            i_q <= i_q + 1'b1;
          end else begin
            rc_q <= rc_q - 1'b1;
            i_q <= '0;
            st_q <= after_q ? S_SCAN : S_DISPATCH;
          end
        end
        S_STAMP: begin
          if (i_q < rc_q && !rst_q[ix]) begin
            rd_q[ix] <= dl_q;
            rst_q[ix] <= 1'b1;
          end
          i_q <= i_q + 1'b1;
          if (i_q == CntW'(Entries - 1)) begin
            i_q <= '0;
            after_q <= 1'b1;
            st_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (i_q >= rc_q) st_q <= S_OUT;
          else if (rst_q[ix] && rd_q[ix] <= it_q.current_frame) st_q <= S_EXAM;
          else i_q <= i_q + 1'b1;
        end
        S_EXAM: if (!ov_q) begin
          if (ev_q[sl] && er_q[sl] == 32'd0) begin
            put(ST_FREED, ed_q[sl], 32'd0, 1'b0, 1'b0, 1'b0);
            ev_q[sl] <= 1'b0;
          end
          st_q <= S_SHIFT;
        end
        S_OUT: if (!ov_q) begin
          put(ST_TICK_DONE, 32'd0, 32'd0, 1'b0, 1'b0, 1'b1);
          after_q <= 1'b0;
          st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rc_q <= CntW'(Entries)) else $error("retire queue overflow");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && out_stall_i |=> ov_q && $stable(o_q)) else $error("result lost");
  a_busy_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_IDLE && in_valid_i |=> in_stall_o) else $error("accept missed");
`endif
endmodule

// ===== test/rcdr_checker.sv =====
// Checker: watches both channels and the register port, predicts and compares results
`timescale 1ns / 100ps
module rcdr_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  rcdr_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  rcdr_pkg::out_item_t out_data_i,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic                pready_i,
  input  logic                paddr_i,
  input  logic [31:0]         pwdata_i,
  output int                  failures_o,
  output int                  outstanding_o,
  output int                  items_o,
  output int                  results_o
);
  import rcdr_pkg::*;

  typedef struct {
    int          slot;
    logic [39:0] deadline;
    bit          stamped;
  } retire_rec_t;

  logic [7:0]  frames_q;
  logic        ent_valid[Entries];
  logic [7:0]  ent_kind[Entries];
  logic [63:0] ent_hash[Entries];
  logic [31:0] ent_handle[Entries];
  logic [31:0] ent_refs[Entries];
  retire_rec_t retire_q[$];
  out_item_t   results_q[$];

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch at %0t: %s got %0h, expected %0h", $realtime, field, got, want);
    failures_o++;
  endtask

  task automatic expect_item(input out_item_t r);
    results_q.insert(results_q.size(), r);
  endtask

  task automatic cache_step(input in_item_t it);
    int s;
    int fs;
    int j;
    int sl;
    logic [40:0] dl;
    out_item_t r;
    retire_rec_t rec;
    s = -1;
    fs = -1;
    r = '0;
    r.last = 1'b1;
    for (int i = 0; i < Entries; i++) begin
      if (s < 0 && ent_valid[i] && ent_kind[i] == it.key_kind && ent_hash[i] == it.key_hash)
        s = i;
      if (fs < 0 && !ent_valid[i]) fs = i;
    end
    case (it.func)
      FN_ENSURE: begin
        if (s >= 0) begin
          r.handle = ent_handle[s];
          if (ent_refs[s] == RefMax) begin
            r.status = ST_SAT_HIT;
            r.ref_count = RefMax;
          end else begin
            if (ent_refs[s] == 0) begin
              for (j = 0; j < retire_q.size(); j++)
                if (retire_q[j].slot == s) begin
                  retire_q.delete(j);
                  r.retire_cancelled = 1'b1;
                  break;
                end
            end
            ent_refs[s]++;
            r.status = ST_HIT;
            r.ref_count = ent_refs[s];
          end
        end else if (!it.upload_ok) begin
          r.status = ST_UP_FAIL;
        end else if (fs < 0) begin
          r.status = ST_FULL;
        end else begin
          ent_valid[fs] = 1'b1;
          ent_kind[fs] = it.key_kind;
          ent_hash[fs] = it.key_hash;
          ent_handle[fs] = it.upload_handle;
          ent_refs[fs] = 1;
          r.status = ST_UPLOADED;
          r.handle = it.upload_handle;
          r.ref_count = 1;
        end
        expect_item(r);
      end
      FN_RELEASE: begin
        if (s < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          if (ent_refs[s] != 0) begin
            ent_refs[s]--;
            if (ent_refs[s] == 0 && retire_q.size() < Entries) begin
              rec.slot = s;
              rec.deadline = '0;
              rec.stamped = 1'b0;
              retire_q.insert(retire_q.size(), rec);
            end
          end
          r.status = ST_RELEASED;
          r.handle = ent_handle[s];
          r.ref_count = ent_refs[s];
          r.unreferenced = (ent_refs[s] == 0);
        end
        expect_item(r);
      end
      FN_TICK: begin
        dl = {1'b0, it.current_frame} + {33'd0, frames_q};
        if (dl > {1'b0, FrameMax}) dl = {1'b0, FrameMax};
        foreach (retire_q[k])
          if (!retire_q[k].stamped) begin
            retire_q[k].deadline = dl[39:0];
            retire_q[k].stamped = 1'b1;
          end
        j = 0;
        while (j < retire_q.size()) begin
          if (retire_q[j].stamped && retire_q[j].deadline <= it.current_frame) begin
            sl = retire_q[j].slot;
            if (ent_valid[sl] && ent_refs[sl] == 0) begin
              r = '0;
              r.status = ST_FREED;
              r.handle = ent_handle[sl];
              expect_item(r);
              ent_valid[sl] = 1'b0;
            end
            retire_q.delete(j);
          end else begin
            j++;
          end
        end
        r = '0;
        r.status = ST_TICK_DONE;
        r.last = 1'b1;
        expect_item(r);
      end
      default: begin
        if (s >= 0) begin
          r.status = ST_LK_HIT;
          r.handle = ent_handle[s];
          r.ref_count = ent_refs[s];
        end else begin
          r.status = ST_LK_MISS;
        end
        expect_item(r);
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      frames_q = 8'd2;
      for (int i = 0; i < Entries; i++) ent_valid[i] = 1'b0;
      retire_q.delete();
      results_q.delete();
      failures_o = 0;
      items_o = 0;
      results_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == RegFrames)
        frames_q = pwdata_i[7:0];
      if (out_valid_i && !out_stall_i) begin
        results_o++;
        if (results_q.size() == 0) begin
          report("unexpected item status", 32'(out_data_i.status), 32'hFFFF_FFFF);
        end else begin
          want = results_q.pop_front();
          if (out_data_i.status != want.status)
            report("status", 32'(out_data_i.status), 32'(want.status));
          if (out_data_i.handle != want.handle)
            report("handle", out_data_i.handle, want.handle);
          if (out_data_i.ref_count != want.ref_count)
            report("ref_count", out_data_i.ref_count, want.ref_count);
          if (out_data_i.unreferenced != want.unreferenced)
            report("unreferenced", 32'(out_data_i.unreferenced), 32'(want.unreferenced));
          if (out_data_i.retire_cancelled != want.retire_cancelled)
            report("retire_cancelled", 32'(out_data_i.retire_cancelled),
                   32'(want.retire_cancelled));
          if (out_data_i.last != want.last)
            report("last", 32'(out_data_i.last), 32'(want.last));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        items_o++;
        cache_step(in_data_i);
      end
    end
    outstanding_o = results_q.size();
  end
endmodule

// ===== test/tb_top.sv =====
// Testbench top: stimulus, register writes, back-pressure and verdict for the cache
`timescale 1ns / 100ps
module tb_top;
  import rcdr_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int KeyPool = 20;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [0:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int failures;
  int outstanding;
  int items_seen;
  int results_seen;
  int cycles = 0;
  int stall_left = 0;
  bit hold_long = 1'b0;
  bit no_idle = 1'b0;
  logic [7:0]  pool_kind[KeyPool];
  logic [63:0] pool_hash[KeyPool];
  logic [39:0] frame_now = '0;

  always #4 clk_i = ~clk_i;

  refcounted_cache_deferred_retire DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  rcdr_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr[0]), .pwdata_i(pwdata),
    .failures_o(failures), .outstanding_o(outstanding),
    .items_o(items_seen), .results_o(results_seen)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("[refcounted_cache_deferred_retire] ERROR");
      $finish;
    end
  end

  // receiver: random stall before each result, or a long hold-off
  always @(posedge clk_i)
    if (out_valid && !out_stall) stall_left = no_idle ? 0 : $urandom_range(0, 19);

  always @(negedge clk_i) begin
    if (hold_long || stall_left > 0) begin
      out_stall <= 1'b1;
      if (stall_left > 0) stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send(input in_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
    end
    @(negedge clk_i);
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic op(input func_e f, input int key, input logic ok, input logic [31:0] h,
                    input logic [39:0] frame);
    in_item_t it;
    it.func = f;
    it.key_kind = pool_kind[key];
    it.key_hash = pool_hash[key];
    it.upload_ok = ok;
    it.upload_handle = h;
    it.current_frame = frame;
    send(it);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_frames(input logic [7:0] v);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= RegFrames;
    pwdata <= {24'($urandom_range(0, 32'hFF_FFFF)), v};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic random_item();
    int sel;
    int key;
    logic [39:0] frame;
    sel = $urandom_range(0, 99);
    key = $urandom_range(0, KeyPool - 1);
    frame = {8'($urandom_range(0, 255)), $urandom};
    if (sel < 40) begin
      op(FN_ENSURE, key, $urandom_range(0, 7) != 0, $urandom, frame);
    end else if (sel < 70) begin
      op(FN_RELEASE, key, 1'($urandom_range(0, 1)), $urandom, frame);
    end else if (sel < 85) begin
      if ($urandom_range(0, 7) == 0) frame_now = frame;
      else frame_now = frame_now + 40'($urandom_range(0, 4));
      op(FN_TICK, key, 1'($urandom_range(0, 1)), $urandom, frame_now);
    end else begin
      op(FN_LOOKUP, key, 1'($urandom_range(0, 1)), $urandom, frame);
    end
  endtask

  initial begin
    logic [7:0] phase_frames[5];
    pool_kind[0] = 8'h00;
    pool_hash[0] = 64'h0;
    pool_kind[1] = 8'hFF;
    pool_hash[1] = 64'hFFFF_FFFF_FFFF_FFFF;
    pool_kind[2] = 8'h01;
    pool_hash[2] = 64'h0;
    for (int i = 3; i < KeyPool; i++) begin
      pool_kind[i] = 8'($urandom_range(0, 255));
      pool_hash[i] = {$urandom, $urandom};
    end
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: misses, hits, release to zero, cancel, expiry, saturated deadline, full table
    op(FN_LOOKUP, 0, 1'b1, 32'h0, '0);
    op(FN_RELEASE, 0, 1'b1, 32'h0, '0);
    op(FN_ENSURE, 0, 1'b0, 32'h1234, '0);
    op(FN_ENSURE, 0, 1'b1, 32'hFFFF_FFFF, '0);
    op(FN_ENSURE, 0, 1'b1, 32'h5, '0);
    op(FN_LOOKUP, 0, 1'b0, 32'h0, '0);
    op(FN_RELEASE, 0, 1'b0, 32'h0, '0);
    op(FN_RELEASE, 0, 1'b0, 32'h0, '0);
    op(FN_RELEASE, 0, 1'b0, 32'h0, '0);
    op(FN_ENSURE, 0, 1'b0, 32'h0, '0);
    op(FN_RELEASE, 0, 1'b0, 32'h0, '0);
    op(FN_TICK, 0, 1'b0, 32'h0, 40'd0);
    op(FN_TICK, 0, 1'b0, 32'h0, 40'd1);
    op(FN_TICK, 0, 1'b0, 32'h0, 40'd2);
    op(FN_LOOKUP, 0, 1'b0, 32'h0, '0);
    op(FN_ENSURE, 1, 1'b1, 32'h0, FrameMax);
    op(FN_ENSURE, 2, 1'b1, 32'hA5A5_5A5A, '0);
    op(FN_RELEASE, 1, 1'b1, 32'h0, '0);
    op(FN_TICK, 1, 1'b1, 32'hFFFF_FFFF, FrameMax);
    for (int i = 3; i <= 17; i++) op(FN_ENSURE, i, 1'b1, $urandom, '0);
    op(FN_ENSURE, 18, 1'b1, 32'hDEAD_BEEF, '0);
    wait_drained();

    phase_frames[0] = 8'd0;
    phase_frames[1] = 8'd255;
    phase_frames[2] = 8'd1;
    phase_frames[3] = 8'd2;
    phase_frames[4] = 8'($urandom_range(3, 254));
    for (int ph = 0; ph < 5; ph++) begin
      set_frames(phase_frames[ph]);
      no_idle = (ph == 3);
      if (ph == 1) begin
        fork
          begin
            hold_long = 1'b1;
            repeat (400) @(negedge clk_i);
            hold_long = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < 23; n++) random_item();
      no_idle = 1'b0;
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    $display("covered %0d items and %0d results over the reset and five written settings,",
             items_seen, results_seen);
    $display("with full table, deferred frees, cancels and long receiver hold-off");
    if (failures == 0) begin
      $display("[refcounted_cache_deferred_retire] OK");
    end else begin
      $display("[refcounted_cache_deferred_retire] ERROR");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hdl/rcdr_pkg.sv
hdl/refcounted_cache_deferred_retire.sv
test/rcdr_checker.sv
test/tb_top.sv
